FILE: src/can_steering_frame_generator_defines.svh
// Assertion macros for the steering CAN frame generator.
// Included by the top level; the checks compile away when SYNTHESIS is defined.
`ifndef CAN_STEERING_FRAME_GENERATOR_DEFINES_SVH
`define CAN_STEERING_FRAME_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define CSFG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("csfg: same-cycle check failed");
`define CSFG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("csfg: next-cycle check failed");
`else
`define CSFG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define CSFG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/csfg_pkg.sv
// Shared types, constants and CRC tables of the steering CAN frame generator.
// No dependencies; imported by the top level, front, queue and back end.
`default_nettype none
package csfg_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_THRESH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEER_CENTRE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CMD_CENTRE = 2'd2;

	localparam logic [15:0] RST_TRIG_THRESH = 16'd20000;
	localparam logic [15:0] RST_STEER_CENTRE = 16'd32376;
	localparam logic [15:0] RST_CMD_CENTRE = 16'd32128;

	localparam logic [28:0] ID_MMI0 = 29'h0CEF13FC;
	localparam logic [28:0] ID_MMI1 = 29'h0CEF5AFC;
	localparam logic [28:0] ID_VSP0 = 29'h0CFF40FB;
	localparam logic [28:0] ID_VSP1 = 29'h0CFF41FB;
	localparam logic [28:0] ID_CMD = 29'h0CAD131C;

	localparam logic [15:0] CRC_POLY = 16'hC86C;
	localparam logic [7:0] TRIG_RELEASED = 8'hFC;
	localparam logic [7:0] TRIG_PULLED = 8'hFD;

	localparam int CNT_W = 4;
	localparam int CNT_N = 1 << CNT_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// Fixed leading bytes 0..4 of the counted frames, byte 0 in the top bits.
	localparam logic [39:0] MMI0_PREFIX = 40'h00_11_5F_30_FF;
	localparam logic [39:0] MMI1_PREFIX = 40'h02_11_5F_30_FF;
	localparam logic [39:0] VSP_PREFIX = 40'hFF_3F_FF_00_FF;
	localparam logic [7:0] VSP_CNT_BASE = 8'hF0;

	typedef struct packed {
		logic [15:0] trig_thresh;
		logic [15:0] steer_centre;
		logic [15:0] cmd_centre;
	} cfg_t;

	// One tick that needs a burst of frames.
	typedef struct packed {
		logic has_mmi;
		logic trig_rel;
		logic [15:0] cmd;
	} job_t;

	typedef struct packed {
		logic [28:0] frame_id;
		logic [7:0][7:0] data;
		logic last_frame;
	} can_frame_t;

	// CRC-16, MSB first, zero start, over six bytes with byte 0 in the top bits.
	function automatic logic [15:0] crc16_six(input logic [47:0] msg);
		logic [15:0] c;
		int k;
		int b;
		c = '0;
		for (k = 0; k < 6; k++) begin
			c = c ^ {msg[47-8*k -: 8], 8'h00};
			for (b = 0; b < 8; b++) begin
				if (c[15]) begin
					c = (c << 1) ^ CRC_POLY;
				end else begin
					c = c << 1;
				end
			end
		end
		return c;
	endfunction

	// Table of CRCs for every counter value; only evaluated for constants.
	function automatic logic [CNT_N*16-1:0] crc_table(input logic [39:0] prefix,
			input logic [7:0] base);
		logic [CNT_N*16-1:0] t;
		int i;
		t = '0;
		for (i = 0; i < CNT_N; i++) begin
			t[i*16 +: 16] = crc16_six({prefix, base + 8'(i)});
		end
		return t;
	endfunction

	localparam logic [CNT_N*16-1:0] MMI0_CRC_TBL = crc_table(MMI0_PREFIX, 8'h00);
	localparam logic [CNT_N*16-1:0] MMI1_CRC_TBL = crc_table(MMI1_PREFIX, 8'h00);
	localparam logic [CNT_N*16-1:0] VSP_CRC_TBL = crc_table(VSP_PREFIX, VSP_CNT_BASE);

endpackage
`default_nettype wire

FILE: src/csfg_tick_if.sv
// Input channel: one millisecond tick with its time and two samples.
// Standalone; carries valid, ready and the tick fields.
`default_nettype none
interface csfg_tick_if;
	logic valid;
	logic ready;
	logic [31:0] time_ms;
	logic [15:0] steer_sample;
	logic [15:0] trigger_sample;

	modport source (output valid, time_ms, steer_sample, trigger_sample, input ready);
	modport sink (input valid, time_ms, steer_sample, trigger_sample, output ready);
endinterface
`default_nettype wire

FILE: src/csfg_frame_if.sv
// Output channel: one extended CAN frame per transfer.
// Standalone; carries valid, ready, identifier, eight payload bytes and the last mark.
`default_nettype none
interface csfg_frame_if;
	logic valid;
	logic ready;
	logic [28:0] frame_id;
	logic [7:0] data_byte0;
	logic [7:0] data_byte1;
	logic [7:0] data_byte2;
	logic [7:0] data_byte3;
	logic [7:0] data_byte4;
	logic [7:0] data_byte5;
	logic [7:0] data_byte6;
	logic [7:0] data_byte7;
	logic last_frame;

	modport source (output valid, frame_id, data_byte0, data_byte1, data_byte2, data_byte3,
		data_byte4, data_byte5, data_byte6, data_byte7, last_frame, input ready);
	modport sink (input valid, frame_id, data_byte0, data_byte1, data_byte2, data_byte3,
		data_byte4, data_byte5, data_byte6, data_byte7, last_frame, output ready);
endinterface
`default_nettype wire

FILE: src/can_steering_frame_generator.sv
// Channel   Dir  Handshake      Carries
// tick      in   valid/ready    time_ms, steer_sample, trigger_sample
// frame     out  valid/ready    frame_id, data_byte0..7, last_frame
// cfg       in   cfg_wr_en      cfg_index, cfg_data (no back-pressure)
//
// A tick enters every cycle while tick.ready is high; a three-stage front pipeline
// classifies it and forms the command, then a four-entry job queue feeds the frame
// sequencer, which loads a job only when idle and emits VSP0, VSP1 and CMD for a
// 100 ms tick, MMI0 and MMI1 first for a 500 ms tick; other ticks cost no back-end
// time. Ticks pass the front stages, queue and output register. Reset is asynchronous
// and clears the counters, queue and valids; tick.ready drops only while the queue is
// full. Top level; depends on csfg_pkg, both channel interfaces, front, queue and back.
`default_nettype none
`include "can_steering_frame_generator_defines.svh"
module can_steering_frame_generator (
	input wire logic clk,
	input wire logic arst_n,
	csfg_tick_if.sink tick,
	csfg_frame_if.source frame,
	input wire logic cfg_wr_en,
	input wire logic [csfg_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [csfg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import csfg_pkg::*;

	cfg_t cfg_q;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t q_wdata;
	job_t q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trig_thresh <= RST_TRIG_THRESH;
			cfg_q.steer_centre <= RST_STEER_CENTRE;
			cfg_q.cmd_centre <= RST_CMD_CENTRE;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TRIG_THRESH: cfg_q.trig_thresh <= cfg_data;
				REG_STEER_CENTRE: cfg_q.steer_centre <= cfg_data;
				REG_CMD_CENTRE: cfg_q.cmd_centre <= cfg_data;
				default: ;
			endcase
		end
	end

	csfg_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick),
		.cfg(cfg_q),
		.q_full(q_full),
		.q_push(q_push),
		.q_wdata(q_wdata)
	);

	csfg_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.full(q_full),
		.pop(q_pop),
		.rdata(q_rdata),
		.empty(q_empty)
	);

	csfg_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_rdata(q_rdata),
		.q_pop(q_pop),
		.frame(frame)
	);

	// The command frame closes every burst.
	`CSFG_ASSERT_IMPLIES(a_cmd_is_last, clk, arst_n, frame.valid && (frame.frame_id == ID_CMD), frame.last_frame)
	// Inside a burst the next frame follows without a gap.
	`CSFG_ASSERT_NEXT(a_burst_no_gap, clk, arst_n, frame.valid && frame.ready && !frame.last_frame, frame.valid)
	// Tick input only stalls on a full job queue.
	`CSFG_ASSERT_IMPLIES(a_stall_on_full, clk, arst_n, !tick.ready, q_full)
	// The sequencer never pops an empty queue.
	`CSFG_ASSERT_IMPLIES(a_pop_not_empty, clk, arst_n, q_pop, !q_empty)
endmodule
`default_nettype wire

FILE: src/csfg_front.sv
// Front end: accepts ticks, tests the time modulo 100 and 500, and computes the
// steering command. Three-stage pipeline; depends on csfg_pkg and csfg_tick_if.
`default_nettype none
module csfg_front (
	input wire logic clk,
	input wire logic arst_n,
	csfg_tick_if.sink tick,
	input wire csfg_pkg::cfg_t cfg,
	input wire logic q_full,
	output logic q_push,
	output csfg_pkg::job_t q_wdata
);
	import csfg_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3;
	logic [15:0] r1_s1;
	logic low2_s1, low2_s2;
	logic neg_s1, neg_s2;
	logic [12:0] mag_s1;
	logic trig_s1, trig_s2;
	logic [10:0] r2_s2;
	logic [28:0] prod_s2;
	logic hit100_s3;
	job_t job_s3;

	logic [16:0] diff;
	logic [15:0] mag;
	logic [8:0] r3;
	logic [6:0] m125;
	logic [10:0] quot;
	logic [15:0] quot_signed;

	// The pipeline stalls only when a tick that needs frames meets a full queue.
	assign en = !(v_s3 && hit100_s3 && q_full);
	assign tick.ready = en;
	assign q_push = v_s3 && hit100_s3 && !q_full;
	assign q_wdata = job_s3;

	assign diff = {1'b0, tick.steer_sample} - {1'b0, cfg.steer_centre};
	assign mag = diff[16] ? 16'(-diff) : diff[15:0];

	// Residue of the time modulo 125 folds down using 256 = 6 (mod 125).
	assign r3 = 9'(r2_s2[10:8]) * 9'd6 + 9'(r2_s2[7:0]);
	always_comb begin
		if (r3 >= 9'd250) begin
			m125 = 7'(r3 - 9'd250);
		end else if (r3 >= 9'd125) begin
			m125 = 7'(r3 - 9'd125);
		end else begin
			m125 = r3[6:0];
		end
	end

	// |diff| / 40 is (|diff| >> 3) / 5, and x / 5 = (x * 0xCCCD) >> 18 here.
	assign quot = prod_s2[28:18];
	assign quot_signed = neg_s2 ? -16'(quot) : 16'(quot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= tick.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r1_s1 <= 16'(tick.time_ms[7:0]) + 16'(tick.time_ms[15:8]) * 16'd6
				+ 16'(tick.time_ms[23:16]) * 16'd36 + 16'(tick.time_ms[31:24]) * 16'd91;
			low2_s1 <= (tick.time_ms[1:0] == 2'b00);
			neg_s1 <= diff[16];
			mag_s1 <= mag[15:3];
			trig_s1 <= (tick.trigger_sample > cfg.trig_thresh);

			r2_s2 <= 11'(r1_s1[15:8]) * 11'd6 + 11'(r1_s1[7:0]);
			prod_s2 <= 29'(mag_s1) * 29'd52429;
			low2_s2 <= low2_s1;
			neg_s2 <= neg_s1;
			trig_s2 <= trig_s1;

			hit100_s3 <= low2_s2 && (m125 == 7'd0 || m125 == 7'd25 || m125 == 7'd50
				|| m125 == 7'd75 || m125 == 7'd100);
			job_s3.has_mmi <= low2_s2 && (m125 == 7'd0);
			job_s3.trig_rel <= trig_s2;
			job_s3.cmd <= quot_signed + cfg.cmd_centre;
		end
	end
endmodule
`default_nettype wire

FILE: src/csfg_queue.sv
// Short job queue between front and back end.
// Register-based FIFO of QUEUE_DEPTH entries; depends on csfg_pkg.
`default_nettype none
module csfg_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire csfg_pkg::job_t wdata,
	output logic full,
	input wire logic pop,
	output csfg_pkg::job_t rdata,
	output logic empty
);
	import csfg_pkg::*;

	job_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;

	assign full = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/csfg_back.sv
// Back end: turns each queued job into its burst of CAN frames, keeps the rolling
// counters and holds the output register. Depends on csfg_pkg and csfg_frame_if.
`default_nettype none
module csfg_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_empty,
	input wire csfg_pkg::job_t q_rdata,
	output logic q_pop,
	csfg_frame_if.source frame
);
	import csfg_pkg::*;

	typedef enum logic [2:0] {
		FR_MMI0,
		FR_MMI1,
		FR_VSP0,
		FR_VSP1,
		FR_CMD
	} frame_sel_t;

	logic busy_q;
	frame_sel_t fr_q;
	job_t job_q;
	logic [CNT_W-1:0] mmi_cnt_q;
	logic [CNT_W-1:0] vsp_cnt_q;
	logic out_valid_q;
	can_frame_t out_q;

	logic out_free;
	logic emit;
	can_frame_t nxt;

	assign out_free = !out_valid_q || frame.ready;
	assign emit = busy_q && out_free;
	assign q_pop = !busy_q && !q_empty;

	always_comb begin
		logic [15:0] crc;
		crc = '0;
		nxt.frame_id = ID_CMD;
		nxt.data = '1;
		nxt.last_frame = 1'b0;
		case (fr_q)
			FR_MMI0, FR_MMI1: begin
				if (fr_q == FR_MMI0) begin
					nxt.frame_id = ID_MMI0;
					crc = MMI0_CRC_TBL[{mmi_cnt_q, 4'h0} +: 16];
				end else begin
					nxt.frame_id = ID_MMI1;
					crc = MMI1_CRC_TBL[{mmi_cnt_q, 4'h0} +: 16];
				end
				nxt.data[0] = MMI0_PREFIX[39:32];
				if (fr_q == FR_MMI1) begin
					nxt.data[0] = MMI1_PREFIX[39:32];
				end
				nxt.data[1] = MMI0_PREFIX[31:24];
				nxt.data[2] = MMI0_PREFIX[23:16];
				nxt.data[3] = MMI0_PREFIX[15:8];
				nxt.data[4] = MMI0_PREFIX[7:0];
				nxt.data[5] = {4'h0, mmi_cnt_q};
				nxt.data[6] = crc[7:0];
				nxt.data[7] = crc[15:8];
			end
			FR_VSP0, FR_VSP1: begin
				nxt.frame_id = (fr_q == FR_VSP0) ? ID_VSP0 : ID_VSP1;
				crc = VSP_CRC_TBL[{vsp_cnt_q, 4'h0} +: 16];
				nxt.data[0] = VSP_PREFIX[39:32];
				nxt.data[1] = VSP_PREFIX[31:24];
				nxt.data[2] = VSP_PREFIX[23:16];
				nxt.data[3] = VSP_PREFIX[15:8];
				nxt.data[4] = VSP_PREFIX[7:0];
				nxt.data[5] = VSP_CNT_BASE | {4'h0, vsp_cnt_q};
				nxt.data[6] = crc[7:0];
				nxt.data[7] = crc[15:8];
			end
			default: begin
				nxt.frame_id = ID_CMD;
				nxt.data[0] = job_q.cmd[7:0];
				nxt.data[1] = job_q.cmd[15:8];
				nxt.data[2] = job_q.trig_rel ? TRIG_RELEASED : TRIG_PULLED;
				nxt.last_frame = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fr_q <= FR_VSP0;
			job_q <= '0;
			mmi_cnt_q <= '0;
			vsp_cnt_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				job_q <= q_rdata;
				fr_q <= q_rdata.has_mmi ? FR_MMI0 : FR_VSP0;
			end else if (emit) begin
				case (fr_q)
					FR_MMI0: fr_q <= FR_MMI1;
					FR_MMI1: begin
						fr_q <= FR_VSP0;
						mmi_cnt_q <= mmi_cnt_q + 1'b1;
					end
					FR_VSP0: fr_q <= FR_VSP1;
					FR_VSP1: begin
						fr_q <= FR_CMD;
						vsp_cnt_q <= vsp_cnt_q + 1'b1;
					end
					default: busy_q <= 1'b0;
				endcase
			end

			if (emit) begin
				out_valid_q <= 1'b1;
				out_q <= nxt;
			end else if (frame.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign frame.valid = out_valid_q;
	assign frame.frame_id = out_q.frame_id;
	assign frame.data_byte0 = out_q.data[0];
	assign frame.data_byte1 = out_q.data[1];
	assign frame.data_byte2 = out_q.data[2];
	assign frame.data_byte3 = out_q.data[3];
	assign frame.data_byte4 = out_q.data[4];
	assign frame.data_byte5 = out_q.data[5];
	assign frame.data_byte6 = out_q.data[6];
	assign frame.data_byte7 = out_q.data[7];
	assign frame.last_frame = out_q.last_frame;
endmodule
`default_nettype wire
